// ----- hw/rtl/lrg_pkg.sv -----
// Shared types, constants and the CORDIC arctangent table for the location report gate.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package lrg_pkg;

  typedef logic signed [30:0] lat_t;
  typedef logic signed [31:0] lon_t;
  typedef logic        [19:0] acc_t;
  typedef logic signed [7:0]  bat_t;
  typedef logic        [39:0] time_t;
  typedef logic        [16:0] accm_t;
  typedef logic        [6:0]  batout_t;
  typedef logic        [24:0] move_t;

  // CORDIC datapath word (Q30 with headroom) and control
  typedef logic signed [33:0] cvec_t;
  typedef enum logic { CORDIC_ROTATE, CORDIC_VECTOR } cordic_mode_e;
  typedef struct packed {
    logic         start;
    cordic_mode_e mode;
  } cordic_ctl_t;

  typedef enum logic [2:0] {
    REG_ENABLE   = 3'd0,
    REG_AT_HOME  = 3'd1,
    REG_MIN_INT  = 3'd2,
    REG_MIN_MOVE = 3'd3,
    REG_MARGIN   = 3'd4,
    REG_POST_GAP = 3'd5
  } reg_idx_e;

  localparam int unsigned TableLen = 40;
  localparam logic [31:0] ATAB [TableLen] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000
  };

  localparam cvec_t              CordicGain = 34'sd652032874;
  localparam logic signed [33:0] TurnUnits  = 34'sd3600000000;
  localparam logic signed [33:0] TurnTwice  = 34'sd7200000000;
  localparam logic signed [32:0] DegScale   = 33'sd1281023894;
  localparam logic signed [32:0] DistScale  = 33'sd80060347;
  localparam logic        [60:0] Q60One     = {1'b1, 60'd0};
  localparam logic        [19:0] Recip10    = 20'd838861;  // ceil(2^23 / 10)

  localparam logic [31:0] RstMinInt  = 32'd60000;
  localparam logic [15:0] RstMinMove = 16'd25;
  localparam logic [15:0] RstMargin  = 16'd150;
  localparam logic [15:0] RstPostGap = 16'd2000;

endpackage
`default_nettype wire

// ----- hw/rtl/lrg_in_if.sv -----
// Input channel of the location report gate: valid/ready plus one fix or resume item.
// Depends on lrg_pkg for the field types.
`default_nettype none
interface lrg_in_if;
  import lrg_pkg::*;
  logic  valid;
  logic  ready;
  logic  mode;
  lat_t  latitude;
  lon_t  longitude;
  acc_t  accuracy_dm;
  bat_t  battery_pct;
  time_t time_ms;

  modport source (output valid, mode, latitude, longitude, accuracy_dm, battery_pct,
                  time_ms, input ready);
  modport sink (input valid, mode, latitude, longitude, accuracy_dm, battery_pct,
                time_ms, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/lrg_out_if.sv -----
// Output channel of the location report gate: valid/ready plus one report decision.
// Depends on lrg_pkg for the field types.
`default_nettype none
interface lrg_out_if;
  import lrg_pkg::*;
  logic    valid;
  logic    ready;
  logic    send;
  lat_t    out_latitude;
  lon_t    out_longitude;
  accm_t   out_accuracy_m;
  batout_t out_battery;
  logic    out_home;
  move_t   move_m;

  modport source (output valid, send, out_latitude, out_longitude, out_accuracy_m,
                  out_battery, out_home, move_m, input ready);
  modport sink (input valid, send, out_latitude, out_longitude, out_accuracy_m,
                out_battery, out_home, move_m, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/lrg_cordic.sv -----
// Iterative CORDIC, one micro-rotation per cycle, in rotation or vectoring mode.
// Depends on lrg_pkg for the arctangent table and datapath types.
`default_nettype none
module lrg_cordic #(
  parameter int unsigned Steps = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lrg_pkg::cordic_ctl_t ctl_i,
  input  logic [31:0]         ang_i,
  input  lrg_pkg::cvec_t      x_i,
  input  lrg_pkg::cvec_t      y_i,
  output logic                done_o,
  output lrg_pkg::cvec_t      x_o,
  output lrg_pkg::cvec_t      y_o,
  output lrg_pkg::cvec_t      z_o
);
  import lrg_pkg::*;

  localparam int unsigned CntW = $clog2(Steps);

  logic            busy_q, done_q, flip_q;
  cordic_mode_e    mode_q;
  logic [CntW-1:0] cnt_q;
  cvec_t           x_q, y_q, z_q;

  logic [5:0] tab_idx;
  cvec_t      dx, dy, at, x_n, y_n, z_n, z0;
  logic       dir, last, flip0;

  always_comb begin
    tab_idx = 6'(cnt_q);
    dx      = y_q >>> cnt_q;
    dy      = x_q >>> cnt_q;
    at      = {2'b00, ATAB[tab_idx]};
    dir     = (mode_q == CORDIC_ROTATE) ? !z_q[33] : y_q[33];
    if (dir) begin
      x_n = x_q - dx;
      y_n = y_q + dy;
      z_n = z_q - at;
    end else begin
      x_n = x_q + dx;
      y_n = y_q - dy;
      z_n = z_q + at;
    end
    last = (cnt_q == CntW'(Steps - 1));
    // fold angles beyond +-90 degrees by a half turn
    z0    = {{2{ang_i[31]}}, ang_i};
    flip0 = 1'b0;
    if (z0 > 34'sh0_4000_0000) begin
      z0    = z0 - 34'sh0_8000_0000;
      flip0 = 1'b1;
    end else if (z0 < -34'sh0_4000_0000) begin
      z0    = z0 + 34'sh0_8000_0000;
      flip0 = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      mode_q <= ctl_i.mode;
      if (ctl_i.mode == CORDIC_ROTATE) begin
        x_q    <= CordicGain;
        y_q    <= '0;
        z_q    <= z0;
        flip_q <= flip0;
      end else begin
        x_q    <= x_i;
        y_q    <= y_i;
        z_q    <= '0;
        flip_q <= 1'b0;
      end
    end else if (busy_q) begin
      z_q <= z_n;
      if (last && flip_q) begin
        x_q <= -x_n;
        y_q <= -y_n;
      end else begin
        x_q <= x_n;
        y_q <= y_n;
      end
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

endmodule
`default_nettype wire

// ----- hw/rtl/lrg_isqrt.sv -----
// Iterative floor square root of a Q60 value, one result bit per cycle.
// Depends on lrg_pkg for the Q60One constant.
`default_nettype none
module lrg_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [60:0] val_i,
  output logic        done_o,
  output logic [30:0] root_o
);
  import lrg_pkg::*;

  logic        busy_q, done_q;
  logic [60:0] v_q, r_q, bit_q;
  logic [61:0] trial;
  logic        take;

  always_comb begin
    trial = {1'b0, r_q} + {1'b0, bit_q};
    take  = ({1'b0, v_q} >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= val_i;
      r_q   <= '0;
      bit_q <= Q60One;
    end else if (busy_q) begin
      if (take) begin
        v_q <= v_q - trial[60:0];
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[30:0];

endmodule
`default_nettype wire

// ----- hw/rtl/location_report_gate.sv -----
// Location report gate top level: register file, sequencer, shared multiplier and result stage.
// Depends on lrg_pkg, lrg_in_if, lrg_out_if, lrg_cordic and lrg_isqrt.
//
//   channel   direction  handshake            carries
//   in_if     sink       valid/ready          mode, position fix, accuracy, battery, time
//   out_if    source     valid/ready          send flag, report fields, move distance
//   apb       slave      psel/penable/pready  six control registers at 4*index
//
// A fix against a stored report runs four CORDIC rotations, two 31-step square roots and
// one CORDIC vectoring run through the one CORDIC unit and the one root unit in turn. A
// first fix, a resume or a disabled item goes from idle straight to the decision and
// output steps. in_if.ready is high only while the sequencer is idle; a result waiting
// on out_if holds the sequencer in its last step. Reset is asynchronous, active low.
`default_nettype none
module location_report_gate #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lrg_in_if.sink      in_if,
  lrg_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lrg_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_BAM_MUL, ST_BAM_ROT, ST_ROT_WAIT, ST_M_C1C2, ST_M_TSL, ST_M_SPSP,
    ST_M_VSL, ST_A_SUM, ST_SQ1, ST_SQ1_WAIT, ST_SQ2_WAIT, ST_VEC_WAIT, ST_M_DIST,
    ST_DECIDE, ST_OUTPUT
  } state_e;

  // control registers
  logic        enable_q, home_q;
  logic [31:0] min_int_q;
  logic [15:0] min_move_q, margin_q, gap_q;

  // captured transaction
  logic  mode_q;
  lat_t  lat_q;
  lon_t  lon_q;
  acc_t  acc_q;
  bat_t  bat_q;
  time_t now_q;

  // tracked state
  logic signed [31:0] st_lat_q, st_lon_q;
  acc_t               st_acc_q;
  time_t              last_q;
  logic               sent_q;
  bat_t               batl_q;

  // datapath
  state_e             state_q;
  logic [1:0]         idx_q;
  cvec_t              cs_q [4];
  logic signed [65:0] prod_q, ap_q;
  logic signed [32:0] v_q, ang_q;
  logic [60:0]        asum_q;
  logic [30:0]        sqx_q;
  logic               res_send_q;
  move_t              res_move_q;

  // result register
  logic    out_vld_q, o_send_q, o_home_q;
  lat_t    o_lat_q;
  lon_t    o_lon_q;
  accm_t   o_accm_q;
  batout_t o_bat_q;
  move_t   o_move_q;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      home_q     <= 1'b0;
      min_int_q  <= RstMinInt;
      min_move_q <= RstMinMove;
      margin_q   <= RstMargin;
      gap_q      <= RstPostGap;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_ENABLE:   enable_q   <= pwdata[0];
        REG_AT_HOME:  home_q     <= pwdata[0];
        REG_MIN_INT:  min_int_q  <= pwdata;
        REG_MIN_MOVE: min_move_q <= pwdata[15:0];
        REG_MARGIN:   margin_q   <= pwdata[15:0];
        REG_POST_GAP: gap_q      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_ENABLE:   prdata = {31'd0, enable_q};
      REG_AT_HOME:  prdata = {31'd0, home_q};
      REG_MIN_INT:  prdata = min_int_q;
      REG_MIN_MOVE: prdata = {16'd0, min_move_q};
      REG_MARGIN:   prdata = {16'd0, margin_q};
      REG_POST_GAP: prdata = {16'd0, gap_q};
      default:      prdata = '0;
    endcase
  end

  // ---------------- shared units ----------------
  cordic_ctl_t cor_ctl;
  logic        cor_done;
  cvec_t       cor_x, cor_y, cor_z;
  logic [31:0] bam;
  logic        sq_start, sq_done;
  logic [60:0] sq_val;
  logic [30:0] sq_root;

  lrg_cordic #(.Steps(CORDIC_STEPS)) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (cor_ctl),
    .ang_i  (bam),
    .x_i    ({3'b000, sqx_q}),
    .y_i    ({3'b000, sq_root}),
    .done_o (cor_done),
    .x_o    (cor_x),
    .y_o    (cor_y),
    .z_o    (cor_z)
  );

  lrg_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .val_i   (sq_val),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  // ---------------- combinational datapath ----------------
  logic signed [33:0] ang_v, t1, t2, t3, red;
  logic signed [32:0] mul_a, mul_b;
  logic [63:0]        r_half, r_full;
  logic signed [65:0] a_sum;
  logic [60:0]        a_clamp;

  always_comb begin
    // angle source for the current rotation
    case (idx_q)
      2'd0:    ang_v = {{2{st_lat_q[31]}}, st_lat_q};
      2'd1:    ang_v = {{3{lat_q[30]}}, lat_q};
      2'd2:    ang_v = {{3{lat_q[30]}}, lat_q} - {{2{st_lat_q[31]}}, st_lat_q};
      default: ang_v = {{2{lon_q[31]}}, lon_q} - {{2{st_lon_q[31]}}, st_lon_q};
    endcase
    // reduce into one turn
    t1 = ang_v + TurnUnits;
    t2 = ang_v + TurnTwice;
    t3 = ang_v - TurnUnits;
    if (ang_v[33]) begin
      red = t1[33] ? t2 : t1;
    end else if (ang_v >= TurnUnits) begin
      red = t3;
    end else begin
      red = ang_v;
    end

    r_half = prod_q[63:0] + 64'h4000_0000;
    r_full = prod_q[63:0] + 64'h2000_0000;
    bam    = idx_q[1] ? r_half[62:31] : r_full[61:30];

    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_BAM_MUL: begin
        mul_a = {1'b0, red[31:0]};
        mul_b = DegScale;
      end
      ST_M_C1C2: begin
        mul_a = cs_q[0][32:0];
        mul_b = cs_q[1][32:0];
      end
      ST_M_TSL: begin
        mul_a = prod_q[62:30];
        mul_b = cs_q[3][32:0];
      end
      ST_M_SPSP: begin
        mul_a = cs_q[2][32:0];
        mul_b = cs_q[2][32:0];
      end
      ST_M_VSL: begin
        mul_a = v_q;
        mul_b = cs_q[3][32:0];
      end
      ST_M_DIST: begin
        mul_a = ang_q;
        mul_b = DistScale;
      end
      default: ;
    endcase

    a_sum = ap_q + prod_q;
    if (a_sum[65]) begin
      a_clamp = '0;
    end else if (a_sum > $signed({5'd0, Q60One})) begin
      a_clamp = Q60One;
    end else begin
      a_clamp = a_sum[60:0];
    end

    cor_ctl.start = (state_q == ST_BAM_ROT) ||
                    (state_q == ST_SQ2_WAIT && sq_done && sq_root != '0);
    cor_ctl.mode  = (state_q == ST_BAM_ROT) ? CORDIC_ROTATE : CORDIC_VECTOR;
    sq_start      = (state_q == ST_SQ1) || (state_q == ST_SQ1_WAIT && sq_done);
    sq_val        = (state_q == ST_SQ1) ? (Q60One - asum_q) : asum_q;
  end

  // ---------------- decision logic ----------------
  logic               first, due_time, due_move, better, worse, gap_block, upd;
  logic signed [40:0] age;
  logic [63:0]        dq, mv;
  logic [21:0]        acc2, last3;
  logic [19:0]        acc_diff;
  logic [20:0]        y_acc;
  logic [40:0]        p_acc;

  always_comb begin
    first     = !sent_q;
    age       = $signed({1'b0, now_q}) - $signed({1'b0, last_q});
    due_time  = first || (age >= $signed({9'd0, min_int_q}));
    dq        = prod_q[63:0];
    due_move  = !first && (dq >= {16'd0, min_move_q, 32'd0});
    mv        = dq + 64'h8000_0000;
    better    = (acc_q != '0) &&
                ((st_acc_q == '0) || (({1'b0, acc_q} + {5'd0, margin_q}) < {1'b0, st_acc_q}));
    acc2      = {1'b0, acc_q, 1'b0};
    last3     = {2'b00, st_acc_q} + {1'b0, st_acc_q, 1'b0};
    acc_diff  = acc_q - st_acc_q;
    worse     = !first && !due_move && (acc_q != '0) && (st_acc_q != '0) &&
                (acc2 > last3) && (acc_diff > {4'd0, margin_q});
    upd       = (due_time || due_move || better) && !worse;
    gap_block = sent_q && (age < $signed({25'd0, gap_q})) && !home_q;
    // round to meters: (acc + 5) / 10 by reciprocal
    y_acc     = {1'b0, st_acc_q} + 21'd5;
    p_acc     = y_acc * Recip10;
  end

  // ---------------- sequencer ----------------
  assign in_if.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      mode_q     <= 1'b0;
      lat_q      <= '0;
      lon_q      <= '0;
      acc_q      <= '0;
      bat_q      <= '0;
      now_q      <= '0;
      st_lat_q   <= '0;
      st_lon_q   <= '0;
      st_acc_q   <= '0;
      last_q     <= '0;
      sent_q     <= 1'b0;
      batl_q     <= -8'sd1;
      cs_q       <= '{default: '0};
      prod_q     <= '0;
      ap_q       <= '0;
      v_q        <= '0;
      ang_q      <= '0;
      asum_q     <= '0;
      sqx_q      <= '0;
      res_send_q <= 1'b0;
      res_move_q <= '0;
      out_vld_q  <= 1'b0;
      o_send_q   <= 1'b0;
      o_home_q   <= 1'b0;
      o_lat_q    <= '0;
      o_lon_q    <= '0;
      o_accm_q   <= '0;
      o_bat_q    <= '0;
      o_move_q   <= '0;
    end else begin
      prod_q <= mul_a * mul_b;
      if (out_vld_q && out_if.ready && state_q != ST_OUTPUT) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_if.valid) begin
            mode_q <= in_if.mode;
            lat_q  <= in_if.latitude;
            lon_q  <= in_if.longitude;
            acc_q  <= in_if.accuracy_dm;
            bat_q  <= in_if.battery_pct;
            now_q  <= in_if.time_ms;
            idx_q  <= '0;
            state_q <= (enable_q && !in_if.mode && sent_q) ? ST_BAM_MUL : ST_DECIDE;
          end
        end
        ST_BAM_MUL: state_q <= ST_BAM_ROT;
        ST_BAM_ROT: state_q <= ST_ROT_WAIT;
        ST_ROT_WAIT: begin
          if (cor_done) begin
            // keep cosines of both latitudes, sines of the half differences
            cs_q[idx_q] <= idx_q[1] ? cor_y : cor_x;
            idx_q       <= idx_q + 2'd1;
            state_q     <= (idx_q == 2'd3) ? ST_M_C1C2 : ST_BAM_MUL;
          end
        end
        ST_M_C1C2: state_q <= ST_M_TSL;
        ST_M_TSL:  state_q <= ST_M_SPSP;
        ST_M_SPSP: begin
          v_q     <= prod_q[62:30];
          state_q <= ST_M_VSL;
        end
        ST_M_VSL: begin
          ap_q    <= prod_q;
          state_q <= ST_A_SUM;
        end
        ST_A_SUM: begin
          asum_q  <= a_clamp;
          state_q <= ST_SQ1;
        end
        ST_SQ1: state_q <= ST_SQ1_WAIT;
        ST_SQ1_WAIT: begin
          if (sq_done) begin
            sqx_q   <= sq_root;
            state_q <= ST_SQ2_WAIT;
          end
        end
        ST_SQ2_WAIT: begin
          if (sq_done) begin
            if (sq_root == '0) begin
              ang_q   <= '0;
              state_q <= ST_M_DIST;
            end else begin
              state_q <= ST_VEC_WAIT;
            end
          end
        end
        ST_VEC_WAIT: begin
          if (cor_done) begin
            ang_q   <= cor_z[33] ? '0 : cor_z[32:0];
            state_q <= ST_M_DIST;
          end
        end
        ST_M_DIST: state_q <= ST_DECIDE;
        ST_DECIDE: begin
          res_send_q <= enable_q && !mode_q && upd && !gap_block;
          res_move_q <= (enable_q && !mode_q && !first) ? mv[56:32] : '0;
          if (enable_q) begin
            if (mode_q) begin
              last_q   <= '0;
              sent_q   <= 1'b0;
              st_acc_q <= '0;
            end else begin
              if (upd) begin
                if (!bat_q[7]) begin
                  batl_q <= bat_q;
                end
                st_lat_q <= {lat_q[30], lat_q};
                st_lon_q <= lon_q;
                if (acc_q != '0) begin
                  st_acc_q <= acc_q;
                end
                if (!gap_block) begin
                  last_q <= now_q;
                  sent_q <= 1'b1;
                end
              end
            end
          end
          state_q <= ST_OUTPUT;
        end
        ST_OUTPUT: begin
          // hold until the result register is free
          if (!out_vld_q || out_if.ready) begin
            out_vld_q <= 1'b1;
            o_send_q  <= res_send_q;
            o_move_q  <= res_move_q;
            if (res_send_q) begin
              o_lat_q  <= st_lat_q[30:0];
              o_lon_q  <= st_lon_q;
              o_accm_q <= p_acc[39:23];
              o_bat_q  <= (batl_q > 8'sd0) ? batl_q[6:0] : '0;
              o_home_q <= home_q;
            end else begin
              o_lat_q  <= '0;
              o_lon_q  <= '0;
              o_accm_q <= '0;
              o_bat_q  <= '0;
              o_home_q <= 1'b0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_if.valid          = out_vld_q;
  assign out_if.send           = o_send_q;
  assign out_if.out_latitude   = o_lat_q;
  assign out_if.out_longitude  = o_lon_q;
  assign out_if.out_accuracy_m = o_accm_q;
  assign out_if.out_battery    = o_bat_q;
  assign out_if.out_home       = o_home_q;
  assign out_if.move_m         = o_move_q;

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for location_report_gate: random fix/resume traffic over the
// valid/ready channels, register phases over APB, and an in-order report predictor.
// Depends on lrg_pkg, lrg_in_if, lrg_out_if and the location_report_gate RTL.
`timescale 1ns / 1ps
module tb_top;
  import lrg_pkg::*;

  localparam int unsigned Steps      = 24;
  localparam longint      TurnDeg7   = 64'sd3600000000;
  localparam longint      DegK       = 64'sd1281023894;
  localparam longint      RadiusK    = 64'sd80060347;
  localparam longint      OneQ60     = 64'sd1 <<< 60;
  localparam int unsigned CycleLimit = 2000000;

  typedef struct {
    logic  mode;
    lat_t  lat;
    lon_t  lon;
    acc_t  acc;
    bat_t  bat;
    time_t tm;
  } fix_t;

  typedef struct {
    logic    send;
    lat_t    lat;
    lon_t    lon;
    accm_t   acc_m;
    batout_t bat;
    logic    home;
    move_t   move;
  } report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lrg_in_if  fix_if ();
  lrg_out_if rep_if ();

  location_report_gate #(.CORDIC_STEPS(Steps)) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (fix_if),
    .out_if  (rep_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor copy of configuration and state
  logic        cfg_enable, cfg_home;
  logic [31:0] cfg_min_int;
  logic [15:0] cfg_min_move, cfg_margin, cfg_post_gap;
  longint      st_lat, st_lon;
  longint      st_acc;
  longint      st_last_sent;
  bit          st_sent_valid;
  longint      st_bat;

  fix_t    pending_fixes[$];
  report_t expected_reports[$];
  fix_t    cur_fix;
  int      error_count = 0;
  int      cycle_count = 0;
  bit      quiet = 1'b0;
  int      src_gap = 0, snk_gap = 0;

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------- fixed-point great-circle distance ----------------
  function automatic logic [31:0] bam_of(longint v, bit half);
    longint r;
    longint unsigned p;
    int sh;
    r = v % TurnDeg7;
    if (r < 0) r += TurnDeg7;
    sh = half ? 31 : 30;
    p = (longint'(r) * DegK + (64'sd1 <<< (sh - 1)));
    return 32'(p >> sh);
  endfunction

  function automatic void cordic_rot(logic [31:0] ang, output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = ang[31] ? longint'(ang) - 64'sh1_0000_0000 : longint'(ang);
    x = 64'sd652032874;
    y = 0;
    flip = 1'b0;
    if (z > 64'sh4000_0000) begin
      z -= 64'sh8000_0000;
      flip = 1'b1;
    end else if (z < -64'sh4000_0000) begin
      z += 64'sh8000_0000;
      flip = 1'b1;
    end
    for (int i = 0; i < Steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAB[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endfunction

  function automatic longint cordic_vec(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    if (y == 0) return 0;
    for (int i = 0; i < Steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(ATAB[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(ATAB[i]);
      end
    end
    return (z < 0) ? 0 : z;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned arc_q32(longint la1, longint lo1, longint la2,
                                              longint lo2);
    longint c1, s1, c2, s2, cp, sp, cl, sl, t, v, a;
    cordic_rot(bam_of(la1, 1'b0), c1, s1);
    cordic_rot(bam_of(la2, 1'b0), c2, s2);
    cordic_rot(bam_of(la2 - la1, 1'b1), cp, sp);
    cordic_rot(bam_of(lo2 - lo1, 1'b1), cl, sl);
    t = (c1 * c2) >>> 30;
    v = (t * sl) >>> 30;
    a = sp * sp + v * sl;
    if (a < 0) a = 0;
    if (a > OneQ60) a = OneQ60;
    t = cordic_vec(longint'(int_sqrt(OneQ60 - a)), longint'(int_sqrt(a)));
    return longint'(t) * RadiusK;
  endfunction

  // ---------------- report decision ----------------
  function automatic report_t decide_report(fix_t f);
    report_t r;
    longint  age, acc, last, margin;
    longint unsigned dq;
    bit first, due_time, due_move, better;
    r = '{default: '0};
    acc = longint'(f.acc);
    last = st_acc;
    margin = longint'(cfg_margin);
    age = longint'(f.tm) - st_last_sent;
    due_move = 1'b0;
    if (!cfg_enable) return r;
    if (f.mode) begin
      st_last_sent = 0;
      st_sent_valid = 1'b0;
      st_acc = 0;
      return r;
    end
    first = !st_sent_valid;
    due_time = first || age >= longint'(cfg_min_int);
    if (!first) begin
      dq = arc_q32(st_lat, st_lon, longint'(f.lat), longint'(f.lon));
      due_move = dq >= (longint'(cfg_min_move) << 32);
      r.move = move_t'((dq + 64'h8000_0000) >> 32);
    end
    better = acc > 0 && (last == 0 || acc + margin < last);
    if (!due_time && !due_move && !better) return r;
    // much worse fix without a move is dropped
    if (!first && !due_move && acc > 0 && last > 0 && 2 * acc > 3 * last &&
        acc - last > margin) return r;
    if (f.bat >= 0) st_bat = longint'(f.bat);
    st_lat = longint'(f.lat);
    st_lon = longint'(f.lon);
    if (acc > 0) st_acc = acc;
    if (st_sent_valid && age < longint'(cfg_post_gap) && !cfg_home) return r;
    st_last_sent = longint'(f.tm);
    st_sent_valid = 1'b1;
    r.send = 1'b1;
    r.lat = lat_t'(st_lat);
    r.lon = lon_t'(st_lon);
    r.acc_m = accm_t'((st_acc + 5) / 10);
    r.bat = (st_bat > 0) ? batout_t'(st_bat) : '0;
    r.home = cfg_home;
    return r;
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fix_if.valid <= 1'b0;
    end else if (!(fix_if.valid && !fix_if.ready)) begin
      if (fix_if.valid) expected_reports.push_back(decide_report(cur_fix));
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        fix_if.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        src_gap <= $urandom_range(0, 2);
        fix_if.valid <= 1'b0;
      end else if (pending_fixes.size() > 0) begin
        cur_fix = pending_fixes.pop_front();
        fix_if.valid       <= 1'b1;
        fix_if.mode        <= cur_fix.mode;
        fix_if.latitude    <= cur_fix.lat;
        fix_if.longitude   <= cur_fix.lon;
        fix_if.accuracy_dm <= cur_fix.acc;
        fix_if.battery_pct <= cur_fix.bat;
        fix_if.time_ms     <= cur_fix.tm;
      end else begin
        fix_if.valid <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------
  function automatic void check_field(string name, longint e, longint a);
    if (e != a) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, e, a);
      error_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    report_t e;
    if (!rst_ni) begin
      rep_if.ready <= 1'b0;
    end else begin
      if (rep_if.valid && rep_if.ready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected report: expected none, actual send=%0b move=%0d",
                   $time, rep_if.send, rep_if.move_m);
          error_count++;
        end else begin
          e = expected_reports.pop_front();
          check_field("send", e.send, rep_if.send);
          check_field("out_latitude", e.lat, rep_if.out_latitude);
          check_field("out_longitude", e.lon, rep_if.out_longitude);
          check_field("out_accuracy_m", e.acc_m, rep_if.out_accuracy_m);
          check_field("out_battery", e.bat, rep_if.out_battery);
          check_field("out_home", e.home, rep_if.out_home);
          check_field("move_m", e.move, rep_if.move_m);
        end
      end
      if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        rep_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        snk_gap <= $urandom_range(0, 2);
        rep_if.ready <= 1'b0;
      end else begin
        rep_if.ready <= 1'b1;
      end
    end
  end

  // ---------------- configuration and stimulus ----------------
  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_ENABLE:   cfg_enable = val[0];
      REG_AT_HOME:  cfg_home = val[0];
      REG_MIN_INT:  cfg_min_int = val;
      REG_MIN_MOVE: cfg_min_move = val[15:0];
      REG_MARGIN:   cfg_margin = val[15:0];
      REG_POST_GAP: cfg_post_gap = val[15:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_fixes.size() > 0 || fix_if.valid || expected_reports.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_config(logic en, logic home, logic [31:0] mi, logic [15:0] mm,
                            logic [15:0] mg, logic [15:0] pg);
    write_reg(REG_ENABLE, {31'd0, en});
    write_reg(REG_AT_HOME, {31'd0, home});
    write_reg(REG_MIN_INT, mi);
    write_reg(REG_MIN_MOVE, {16'd0, mm});
    write_reg(REG_MARGIN, {16'd0, mg});
    write_reg(REG_POST_GAP, {16'd0, pg});
  endtask

  // track of the simulated device, advanced by the random part
  longint trk_lat, trk_lon, trk_time;

  function automatic fix_t mk(logic md, longint la, longint lo, longint ac, longint bt,
                              longint tm);
    fix_t f;
    f.mode = md; f.lat = lat_t'(la); f.lon = lon_t'(lo);
    f.acc = acc_t'(ac); f.bat = bat_t'(bt); f.tm = time_t'(tm);
    return f;
  endfunction

  function automatic longint pick_acc();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return $urandom_range(1, 100);
      2: return $urandom_range(100, 2000);
      3: return $urandom_range(0, 20'hFFFFF);
      default: return $urandom_range(20, 400);
    endcase
  endfunction

  task automatic random_fixes(int n);
    fix_t f;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 19))
        0: f = mk(1'b1, $urandom, $urandom, $urandom, $urandom, $urandom);
        1, 2: begin
          // raw noise: every bit of every field but the mode
          f = mk(1'b0, $urandom, $urandom, $urandom, $urandom_range(0, 255),
                 {$urandom_range(0, 255), $urandom});
          if ($urandom_range(0, 1)) trk_time = longint'(f.tm);
        end
        3: begin
          trk_lat = $urandom_range(0, 1800000000) - 900000000;
          trk_lon = longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
          trk_time += $urandom_range(0, 200000);
          f = mk(1'b0, trk_lat, trk_lon, pick_acc(), $urandom_range(0, 101) - 1, trk_time);
        end
        4: begin
          trk_time -= $urandom_range(0, 5000);
          if (trk_time < 0) trk_time = 0;
          f = mk(1'b0, trk_lat, trk_lon, pick_acc(), $urandom_range(0, 101) - 1, trk_time);
        end
        default: begin
          trk_lat += longint'($urandom_range(0, 8000)) - 4000;
          trk_lon += longint'($urandom_range(0, 8000)) - 4000;
          trk_time += $urandom_range(0, 3) == 0 ? $urandom_range(0, 90000)
                                                : $urandom_range(0, 4000);
          f = mk(1'b0, trk_lat, trk_lon, pick_acc(), $urandom_range(0, 101) - 1, trk_time);
        end
      endcase
      pending_fixes.push_back(f);
    end
  endtask

  initial begin
    fix_if.valid = 1'b0;
    fix_if.mode = 1'b0;
    fix_if.latitude = '0;
    fix_if.longitude = '0;
    fix_if.accuracy_dm = '0;
    fix_if.battery_pct = '0;
    fix_if.time_ms = '0;
    rep_if.ready = 1'b0;
    cfg_enable = 1'b0; cfg_home = 1'b0;
    cfg_min_int = RstMinInt; cfg_min_move = RstMinMove;
    cfg_margin = RstMargin; cfg_post_gap = RstPostGap;
    st_lat = 0; st_lon = 0; st_acc = 0; st_last_sent = 0;
    st_sent_valid = 1'b0; st_bat = -1;
    trk_lat = 478000000; trk_lon = 85000000; trk_time = 1000;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // disabled after reset: nothing changes
    pending_fixes.push_back(mk(1'b0, 100, 200, 50, 40, 5000));
    pending_fixes.push_back(mk(1'b1, 0, 0, 0, 0, 0));
    wait_drained();

    // directed: enabled with reset defaults
    write_reg(REG_ENABLE, 32'd1);
    pending_fixes.push_back(mk(1'b0, 900000000, 1800000000, 1000000, 100, 1000));
    pending_fixes.push_back(mk(1'b0, 900000000, 1800000000, 1000000, 100, 1500));
    pending_fixes.push_back(mk(1'b0, -900000000, -1800000000, 0, -1, 4000));
    pending_fixes.push_back(mk(1'b0, -900000000, -1800000000, 10, 127, 7000));
    pending_fixes.push_back(mk(1'b0, -900000000, -1800000000, 5000, 50, 9000));
    pending_fixes.push_back(mk(1'b0, -899999000, -1800000000, 20, -128, 12000));
    pending_fixes.push_back(mk(1'b0, -899999000, -1800000000, 20, 0, 1000));
    pending_fixes.push_back(mk(1'b0, -1073741824, -64'sd2147483648, 0, 1, 80000));
    pending_fixes.push_back(mk(1'b0, 1073741823, 2147483647, 20'hFFFFF, 99, 150000));
    pending_fixes.push_back(mk(1'b1, 5, 5, 5, 5, 5));
    pending_fixes.push_back(mk(1'b0, 0, 0, 0, -1, 40'hFF_FFFF_FFFF));
    pending_fixes.push_back(mk(1'b0, 2000, 0, 30, 20, 40'hFF_FFFF_FFFF));
    pending_fixes.push_back(mk(1'b0, 2300, 0, 31, 20, 40'hFF_FFFF_0000));
    pending_fixes.push_back(mk(1'b0, 0, 1800000000, 31, 20, 40'h00_0000_0000));
    random_fixes(70);
    wait_drained();

    set_config(1'b1, 1'b1, 32'd0, 16'd0, 16'd0, 16'd0);
    random_fixes(90);
    wait_drained();

    set_config(1'b1, 1'b0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_fixes(90);
    wait_drained();

    set_config(1'b1, 1'b0, 32'd30000, 16'd10, 16'd50, 16'd1000);
    random_fixes(90);
    wait_drained();

    set_config(1'b0, 1'b1, 32'd1000, 16'd5, 16'd0, 16'd2000);
    random_fixes(30);
    wait_drained();

    set_config(1'b1, 1'b1, 32'd5000, 16'd100, 16'd300, 16'd500);
    random_fixes(90);
    wait_drained();

    set_config(1'b1, 1'b0, RstMinInt, RstMinMove, RstMargin, RstPostGap);
    random_fixes(70);
    while (pending_fixes.size() > 60) @(posedge clk_i);
    quiet = 1'b1;
    random_fixes(70);

    while (pending_fixes.size() > 0 || fix_if.valid || expected_reports.size() > 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/lrg_pkg.sv
hw/rtl/lrg_in_if.sv
hw/rtl/lrg_out_if.sv
hw/rtl/lrg_cordic.sv
hw/rtl/lrg_isqrt.sv
hw/rtl/location_report_gate.sv
dv/tb_top.sv
